>>> src/chol_pkg.sv
`default_nettype none
package chol_pkg;
  localparam int MAX_N = 8;
  localparam int FRAC_BITS = 16;
  localparam int TRI_DEPTH = MAX_N * (MAX_N + 1) / 2;
  localparam int IDXW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int NW = $clog2(MAX_N + 1);
  localparam int ADDRW = $clog2(TRI_DEPTH);
  localparam int CNTW = $clog2(TRI_DEPTH + 1);
  localparam int TW = ADDRW + IDXW + 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PIVOT = CFG_IDX_W'(1);

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [63:0] S64_MAX = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic [ADDRW-1:0] tri_addr(input logic [IDXW-1:0] r,
                                                input logic [IDXW-1:0] c);
    logic [TW-1:0] t;
    t = (TW'(r) * (TW'(r) + TW'(1))) >> 1;
    return ADDRW'(t + TW'(c));
  endfunction
endpackage
`default_nettype wire

>>> src/chol_if.sv
`default_nettype none
interface chol_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] element_value;
  logic last_element;
  modport source (output valid, element_value, last_element, input ready);
  modport sink (input valid, element_value, last_element, output ready);
endinterface

interface chol_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] factor_value;
  logic [2:0] row;
  logic [2:0] column;
  logic status;
  logic last_result;
  modport source (output valid, factor_value, row, column, status, last_result, input ready);
  modport sink (input valid, factor_value, row, column, status, last_result, output ready);
endinterface

interface chol_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/chol_div.sv
`default_nettype none
module chol_div
  import chol_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic done,
  output logic signed [31:0] quotient
);
  logic [63:0] mag;
  logic [32:0] part;
  logic [31:0] dv;
  logic neg;
  logic busy;
  logic [6:0] cnt;
  logic [32:0] trial;
  logic [63:0] negq;

  assign trial = {part[31:0], mag[63]};
  assign negq = 64'd0 - mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        neg <= dividend[63];
        mag <= dividend[63] ? 64'd0 - dividend : dividend;
        dv <= divisor;
        part <= 33'd0;
      end else if (busy) begin
        if (cnt == 7'd64) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) quotient <= (mag > 64'h7fffffff) ? S32_MAX : mag[31:0];
          else quotient <= (mag > 64'h80000000) ? S32_MIN : negq[31:0];
        end else begin
          cnt <= cnt + 7'd1;
          if (trial >= {1'b0, dv}) begin
            part <= trial - {1'b0, dv};
            mag <= {mag[62:0], 1'b1};
          end else begin
            part <= trial;
            mag <= {mag[62:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> src/chol_sqrt.sv
`default_nettype none
module chol_sqrt
  import chol_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [63:0] radicand,
  output logic done,
  output logic signed [31:0] root_out
);
  logic [63:0] rad;
  logic [35:0] acc;
  logic [31:0] root;
  logic busy;
  logic [5:0] cnt;
  logic [35:0] sh;
  logic [35:0] trial;

  assign sh = {acc[33:0], rad[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        rad <= radicand;
        acc <= 36'd0;
        root <= 32'd0;
      end else if (busy) begin
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
          root_out <= root[31] ? S32_MAX : root;
        end else begin
          cnt <= cnt + 6'd1;
          rad <= {rad[61:0], 2'b00};
          if (sh >= trial) begin
            acc <= sh - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            acc <= sh;
            root <= {root[30:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> src/cholesky_factorization_top.sv
// Loading: one element word per cycle while idle; factoring starts on the last mark.
// Factoring: per L entry, read/multiply/accumulate on the factor memory's two read
// ports, then a divide (j < i) or a square root (diagonal); a diagonal remainder not
// above min_pivot instead ends the run with a single status word.
// Output: each result word is read, registered and held until taken, and the next
// is read only after that. No element is taken while factoring or emitting.
// Reset (rst, synchronous): idle, load count 0, matrix_size 8, min_pivot 1.
`default_nettype none
module cholesky_factorization_top
  import chol_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  chol_cfg_if.sink cfg,
  chol_in_if.sink elem,
  chol_out_if.source result
);
  typedef enum logic [3:0] {
    IDLE, ELEM, ELEM2, DOT, REM, DIVW, SQW, FAILW, OUT_RD, OUT_LD, OUTW
  } state_t;

  state_t state;
  logic [3:0] matrix_size;
  logic [15:0] min_pivot;
  logic [CNTW-1:0] load_count;
  logic [NW-1:0] n;
  logic [IDXW-1:0] i, j, k, orow, ocol;

  logic signed [31:0] input_matrix_store [TRI_DEPTH];
  logic signed [31:0] factor_store [TRI_DEPTH];
  logic signed [31:0] ia_rdata, fa_rdata, fb_rdata;
  logic [ADDRW-1:0] ia_addr, fa_addr, fb_addr;
  logic wr_en;
  logic signed [31:0] wr_data;

  logic signed [31:0] a_q, piv;
  logic signed [63:0] prod, acc, remv, a64, limit;
  logic rd_v, mul_v;
  logic div_start, div_done, sq_start, sq_done;
  logic signed [31:0] div_q, sq_q;
  logic [31:0] divisor;
  logic [NW-1:0] n_cfg;

  assign cfg.ready = 1'b1;
  assign elem.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= 4'd8;
      min_pivot <= 16'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MATRIX_SIZE: matrix_size <= cfg.data[3:0];
        REG_MIN_PIVOT: min_pivot <= cfg.data;
        default: ;
      endcase
    end
  end

  assign n_cfg = (matrix_size == 4'd0) ? NW'(1) :
                 (32'(matrix_size) > MAX_N) ? NW'(MAX_N) : NW'(matrix_size);
  assign a64 = 64'(a_q) <<< FRAC_BITS;
  assign remv = sat_sub64(a64, acc);
  assign limit = 64'(min_pivot) <<< FRAC_BITS;
  assign divisor = (piv < 32'sd1) ? 32'd1 : piv;
  assign div_start = (state == REM) && (j < i);
  assign sq_start = (state == REM) && (j == i) && (remv > limit);

  always_comb begin
    ia_addr = tri_addr(i, j);
    fb_addr = (state == DOT) ? tri_addr(j, k) : tri_addr(j, j);
    fa_addr = (state == OUT_RD) ? tri_addr(orow, ocol) : tri_addr(i, k);
    wr_en = ((state == DIVW) && div_done) || ((state == SQW) && sq_done);
    wr_data = (state == DIVW) ? div_q : sq_q;
  end

  always_ff @(posedge clk) begin
    if (elem.valid && elem.ready && load_count < CNTW'(TRI_DEPTH))
      input_matrix_store[load_count[ADDRW-1:0]] <= elem.element_value;
    ia_rdata <= input_matrix_store[ia_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) factor_store[tri_addr(i, j)] <= wr_data;
    fa_rdata <= factor_store[fa_addr];
    fb_rdata <= factor_store[fb_addr];
  end

  chol_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(remv), .divisor(divisor),
    .done(div_done), .quotient(div_q)
  );

  chol_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(remv),
    .done(sq_done), .root_out(sq_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      load_count <= '0;
      result.valid <= 1'b0;
      rd_v <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v <= 1'b0;
      mul_v <= rd_v;
      if (rd_v) prod <= fa_rdata * fb_rdata;
      if (mul_v) acc <= sat_add64(acc, prod);
      case (state)
        IDLE: begin
          if (elem.valid) begin
            if (load_count < CNTW'(TRI_DEPTH)) load_count <= load_count + CNTW'(1);
            if (elem.last_element) begin
              load_count <= '0;
              n <= n_cfg;
              i <= '0;
              j <= '0;
              state <= ELEM;
            end
          end
        end
        ELEM: begin
          k <= '0;
          acc <= '0;
          state <= ELEM2;
        end
        ELEM2: begin
          a_q <= ia_rdata;
          piv <= fb_rdata;
          state <= DOT;
        end
        DOT: begin
          if (k < j) begin
            rd_v <= 1'b1;
            k <= k + IDXW'(1);
          end else if (!rd_v && !mul_v) begin
            state <= REM;
          end
        end
        REM: begin
          if (j < i) state <= DIVW;
          else if (remv > limit) state <= SQW;
          else begin
            result.valid <= 1'b1;
            result.factor_value <= '0;
            result.row <= 3'(i);
            result.column <= 3'(i);
            result.status <= 1'b1;
            result.last_result <= 1'b1;
            state <= FAILW;
          end
        end
        DIVW, SQW: begin
          if ((state == DIVW && div_done) || (state == SQW && sq_done)) begin
            if (j < i) begin
              j <= j + IDXW'(1);
              state <= ELEM;
            end else if (NW'(i) == n - NW'(1)) begin
              orow <= '0;
              ocol <= '0;
              state <= OUT_RD;
            end else begin
              i <= i + IDXW'(1);
              j <= '0;
              state <= ELEM;
            end
          end
        end
        FAILW: begin
          if (result.ready) begin
            result.valid <= 1'b0;
            state <= IDLE;
          end
        end
        OUT_RD: state <= OUT_LD;
        OUT_LD: begin
          result.valid <= 1'b1;
          result.factor_value <= fa_rdata;
          result.row <= 3'(orow);
          result.column <= 3'(ocol);
          result.status <= 1'b0;
          result.last_result <= (NW'(orow) == n - NW'(1)) && (ocol == orow);
          state <= OUTW;
        end
        OUTW: begin
          if (result.ready) begin
            result.valid <= 1'b0;
            if (result.last_result) state <= IDLE;
            else begin
              if (ocol == orow) begin
                orow <= orow + IDXW'(1);
                ocol <= '0;
              end else begin
                ocol <= ocol + IDXW'(1);
              end
              state <= OUT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/chol_checker.sv
`default_nettype none
module chol_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_value,
  input wire logic [2:0] out_row,
  input wire logic [2:0] out_column,
  input wire logic out_status,
  input wire logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row))
    else $error("result word changed while stalled");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("element taken while result pending");
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_last && out_value == 32'd0 && out_row == out_column)
    else $error("bad status word");
  a_lower: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_column <= out_row)
    else $error("entry above diagonal");
endmodule

bind cholesky_factorization_top chol_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(elem.ready),
  .out_valid(result.valid), .out_ready(result.ready), .out_value(result.factor_value),
  .out_row(result.row), .out_column(result.column), .out_status(result.status),
  .out_last(result.last_result)
);
`default_nettype wire

>>> bench/cholesky_factorization_tb_if.sv
`timescale 1ns / 100ps
// The block's channel interfaces are declared in src/chol_if.sv; this file
// only gathers the shared testbench types.
package chol_tb_pkg;
  typedef struct packed {
    logic signed [31:0] factor_value;
    logic [2:0]         row;
    logic [2:0]         column;
    logic               status;
    logic               last_result;
  } factor_word_t;
endpackage

>>> bench/cholesky_factorization_top_tb.sv
`timescale 1ns / 100ps
module cholesky_factorization_top_tb;
  import chol_pkg::*;
  import chol_tb_pkg::*;

  class chol_scoreboard;
    int unsigned       order;
    logic [15:0]       pivot_floor;
    logic signed [31:0] a_store[TRI_DEPTH];
    logic signed [31:0] l_store[TRI_DEPTH];
    int unsigned       fill;
    factor_word_t      pending[$];
    int unsigned       mismatches;

    function new();
      order = 8;
      pivot_floor = 16'd1;
      fill = 0;
      mismatches = 0;
      foreach (a_store[k]) begin
        a_store[k] = '0;
        l_store[k] = '0;
      end
    endfunction

    function automatic int unsigned tix(int unsigned r, int unsigned c);
      return r * (r + 1) / 2 + c;
    endfunction

    function automatic longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'sh8000000000000000
                                                         : 64'sh7fffffffffffffff;
      return s;
    endfunction

    function automatic longint ssub(longint a, longint b);
      longint s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? 64'sh8000000000000000
                                                         : 64'sh7fffffffffffffff;
      return s;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] d);
      if (idx == REG_MATRIX_SIZE) order = d[3:0];
      else if (idx == REG_MIN_PIVOT) pivot_floor = d;
    endfunction

    function void factor();
      int unsigned n;
      longint a, rem, dot, d, floor_q;
      factor_word_t w;
      n = order;
      if (n == 0) n = 1;
      if (n > MAX_N) n = MAX_N;
      floor_q = longint'(pivot_floor) <<< FRAC_BITS;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = 0; j <= i; j++) begin
          a = longint'(a_store[tix(i, j)]) <<< FRAC_BITS;
          dot = 0;
          for (int unsigned k = 0; k < j; k++)
            dot = sadd(dot, longint'(l_store[tix(i, k)]) * longint'(l_store[tix(j, k)]));
          rem = ssub(a, dot);
          if (j < i) begin
            d = longint'(l_store[tix(j, j)]);
            if (d < 1) d = 1;
            l_store[tix(i, j)] = clip32(rem / d);
          end else if (!(rem > floor_q) || rem <= 0) begin
            w.factor_value = '0;
            w.row = i[2:0];
            w.column = i[2:0];
            w.status = 1'b1;
            w.last_result = 1'b1;
            pending.push_back(w);
            return;
          end else begin
            l_store[tix(i, i)] = clip32(longint'(root_floor(rem)));
          end
        end
      end
      for (int unsigned i = 0; i < n; i++)
        for (int unsigned j = 0; j <= i; j++) begin
          w.factor_value = l_store[tix(i, j)];
          w.row = i[2:0];
          w.column = j[2:0];
          w.status = 1'b0;
          w.last_result = (i == n - 1 && j == i);
          pending.push_back(w);
        end
    endfunction

    function void note_element(logic signed [31:0] v, logic last);
      if (fill < TRI_DEPTH) begin
        a_store[fill] = v;
        fill++;
      end
      if (last) begin
        fill = 0;
        factor();
      end
    endfunction

    function void check_word(factor_word_t got);
      factor_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %0d row %0d col %0d status %0b last %0b",
                   got.factor_value, got.row, got.column, got.status, got.last_result);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d r%0d c%0d s%0b l%0b, got %0d r%0d c%0d s%0b l%0b",
                   want.factor_value, want.row, want.column, want.status, want.last_result,
                   got.factor_value, got.row, got.column, got.status, got.last_result);
      end
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  chol_cfg_if cfg ();
  chol_in_if elem ();
  chol_out_if result ();

  cholesky_factorization_top i_dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .elem(elem.sink), .result(result.source)
  );

  chol_scoreboard factor_board;
  int unsigned cycle_count;
  bit calm;
  int unsigned dim;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    elem.valid = 1'b0;
    elem.element_value = '0;
    elem.last_element = 1'b0;
    result.ready = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    cycle_count = 0;
    dim = 8;
    factor_board = new();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    factor_word_t w;
    if (!rst && result.valid && result.ready) begin
      w.factor_value = result.factor_value;
      w.row = result.row;
      w.column = result.column;
      w.status = result.status;
      w.last_result = result.last_result;
      factor_board.check_word(w);
    end
  end

  always @(negedge clk) begin
    result.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 11);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    factor_board.write_reg(idx, d);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_element(logic signed [31:0] v, logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) @(negedge clk);
    elem.valid <= 1'b1;
    elem.element_value <= v;
    elem.last_element <= last;
    @(posedge clk);
    while (!elem.ready) @(posedge clk);
    factor_board.note_element(v, last);
    @(negedge clk);
    elem.valid <= 1'b0;
  endtask

  task automatic drain();
    while (factor_board.pending.size() != 0) @(posedge clk);
    repeat (6000) @(posedge clk);
  endtask

  task automatic set_order(int unsigned n);
    drain();
    write_reg(REG_MATRIX_SIZE, 16'(n));
    dim = (n == 0) ? 1 : (n > MAX_N ? MAX_N : n);
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom;
  endfunction

  // Send a matrix A = M*M^T + diag, positive definite before its entries are shifted left by 16 and clipped.
  task automatic send_spd(int unsigned mag);
    int m[MAX_N][MAX_N];
    longint s;
    for (int i = 0; i < dim; i++)
      for (int j = 0; j <= i; j++)
        m[i][j] = $urandom_range(2 * mag) - mag;
    for (int i = 0; i < dim; i++)
      for (int j = 0; j <= i; j++) begin
        s = 0;
        for (int k = 0; k <= j; k++) s += longint'(m[i][k]) * m[j][k];
        if (i == j) s += 2 + $urandom_range(mag);
        s = s <<< 16;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        send_element(32'(s), i == dim - 1 && j == i);
      end
  endtask

  task automatic send_noise(int unsigned count);
    for (int k = 0; k < count; k++)
      send_element(rand_word(), k == count - 1);
  endtask

  initial begin
    int unsigned tri_n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_order(1);
    send_element(32'sh7fffffff, 1'b1);
    send_element(32'sh80000000, 1'b1);
    send_element(32'sh00010001, 1'b1);
    send_element(32'sh00000000, 1'b1);
    set_order(2);
    send_element(32'sh00040000, 1'b0);
    send_element(32'sh7fffffff, 1'b0);
    send_element(32'sh00090000, 1'b1);
    send_element(32'sh00040000, 1'b0);
    send_element(32'sh00020000, 1'b0);
    send_element(32'sh00010000, 1'b1);
    drain();
    write_reg(REG_MIN_PIVOT, 16'hffff);
    send_element(32'sh7fffffff, 1'b0);
    send_element(32'sh80000000, 1'b0);
    send_element(32'sh7fffffff, 1'b1);
    set_order(0);
    send_element(32'sh00100000, 1'b1);
    set_order(15);
    write_reg(REG_MIN_PIVOT, 16'h0000);
    for (int k = 0; k < 40; k++) send_element(32'sh00010000 << (k % 14), k == 39);

    calm = 1'b1;
    set_order(3);
    send_spd(4);
    calm = 1'b0;

    for (int p = 0; p < 20; p++) begin
      if (p % 5 == 0) begin
        set_order($urandom_range(8, 1));
        drain();
        write_reg(REG_MIN_PIVOT, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2)));
      end
      tri_n = dim * (dim + 1) / 2;
      if ($urandom_range(4) == 0) send_noise(tri_n);
      else send_spd($urandom_range(1) ? 100 : 3);
      if (p == 12) calm = 1'b1;
      if (p == 16) calm = 1'b0;
    end

    drain();
    if (factor_board.mismatches == 0 && factor_board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
src/chol_pkg.sv
src/chol_if.sv
src/chol_div.sv
src/chol_sqrt.sv
src/cholesky_factorization_top.sv
src/chol_checker.sv
bench/cholesky_factorization_tb_if.sv
bench/cholesky_factorization_top_tb.sv
